>>> hdl/rgb_led_pattern_animator_defines.svh
// Assertion macros shared by the LED animator modules.
// Each macro expects a clock named clk in scope; RLPA_ASSERT also an active-low reset named arst_n.
`ifndef RGB_LED_PATTERN_ANIMATOR_DEFINES_SVH
`define RGB_LED_PATTERN_ANIMATOR_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define RLPA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included
`define RLPA_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/rlpa_pkg.sv
// Shared types and constants for the RGB LED pattern animator.
// No dependencies; imported by every module of the block.
package rlpa_pkg;

	// Command codes
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_SET    = 1'b1;

	// Pattern codes
	localparam logic [3:0] PAT_OFF          = 4'd0;
	localparam logic [3:0] PAT_SOLID_BLUE   = 4'd1;
	localparam logic [3:0] PAT_SOLID_GREEN  = 4'd2;
	localparam logic [3:0] PAT_SOLID_YELLOW = 4'd3;
	localparam logic [3:0] PAT_SOLID_RED    = 4'd4;
	localparam logic [3:0] PAT_SOLID_CYAN   = 4'd5;
	localparam logic [3:0] PAT_BLINK_BLUE   = 4'd6;
	localparam logic [3:0] PAT_BLINK_GREEN  = 4'd7;
	localparam logic [3:0] PAT_BLINK_YELLOW = 4'd8;
	localparam logic [3:0] PAT_BLINK_RED    = 4'd9;
	localparam logic [3:0] PAT_PULSE_BLUE   = 4'd10;

	// Configuration register indexes
	localparam logic [1:0] CFG_SLOW_BLINK = 2'd0;
	localparam logic [1:0] CFG_FAST_BLINK = 2'd1;
	localparam logic [1:0] CFG_PULSE_TICK = 2'd2;
	localparam logic [1:0] CFG_PULSE_STEP = 2'd3;

	// Configuration reset values
	localparam logic [15:0] SLOW_BLINK_RST = 16'd1000;
	localparam logic [15:0] FAST_BLINK_RST = 16'd250;
	localparam logic [7:0]  PULSE_TICK_RST = 8'd10;
	localparam logic [7:0]  PULSE_STEP_RST = 8'd5;

	localparam logic [7:0] LEVEL_MAX = 8'd255;

	typedef struct packed {
		logic        op;
		logic [3:0]  pattern;
		logic [31:0] now_ms;
	} rlpa_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rlpa_out_t;

	typedef struct packed {
		logic [15:0] slow_blink_ms;
		logic [15:0] fast_blink_ms;
		logic [7:0]  pulse_tick_ms;
		logic [7:0]  pulse_step;
	} rlpa_cfg_t;

	typedef struct packed {
		logic      valid;
		rlpa_out_t data;
	} rlpa_res_t;

endpackage

>>> hdl/rgb_led_pattern_animator.sv
// RGB LED pattern animator: one command beat in, zero or one colour beat out.
// Depends on rlpa_pkg, rlpa_cfg, rlpa_core and rlpa_skid.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries commands. A set
//   command (op high) selects a pattern and restarts its timing at now_ms; it
//   gives no colour. An update (op low) advances the animation to now_ms and
//   gives one colour, except for the flash and unused pattern codes.
//   Output channel (out_valid / out_stall / out_data) carries the colours.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   blink intervals and the pulse tick and step; cfg_ready is always high.
// Output: each colour is registered in the output register, via the skid stage when stalled.
// Throughput: one command per cycle while in_stall is low; the animation state registers are
//   updated by single-cycle logic, so a command can follow in the next cycle.
// Stall: the output register plus a one-entry skid stage absorb a stalled
//   colour; in_stall rises only once the skid stage is occupied.
// Reset: arst_n clears the animation to pattern off with the pulse rising,
//   restores the register defaults (1000, 250, 10, 5) and empties the output.
module rgb_led_pattern_animator
	import rlpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  rlpa_in_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output rlpa_out_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	rlpa_cfg_t cfg;
	rlpa_res_t res;
	logic      full;
	logic      accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign accept    = in_valid && !full;

	rlpa_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	rlpa_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (in_data),
		.cfg    (cfg),
		.res    (res)
	);

	rlpa_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

>>> hdl/rlpa_cfg.sv
// Configuration register file of the LED animator.
// Depends on rlpa_pkg for register indexes, reset values and the config struct.
module rlpa_cfg
	import rlpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data,
	output rlpa_cfg_t   cfg
);

	rlpa_cfg_t cfg_q;

	// Write the addressed register on a completed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow_blink_ms <= SLOW_BLINK_RST;
			cfg_q.fast_blink_ms <= FAST_BLINK_RST;
			cfg_q.pulse_tick_ms <= PULSE_TICK_RST;
			cfg_q.pulse_step    <= PULSE_STEP_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_SLOW_BLINK: cfg_q.slow_blink_ms <= wr_data;
				CFG_FAST_BLINK: cfg_q.fast_blink_ms <= wr_data;
				CFG_PULSE_TICK: cfg_q.pulse_tick_ms <= wr_data[7:0];
				CFG_PULSE_STEP: cfg_q.pulse_step    <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/rlpa_core.sv
// Animation state and colour logic of the LED animator: one command per cycle.
// Depends on rlpa_pkg and the assertion macros in rgb_led_pattern_animator_defines.svh.
`include "rgb_led_pattern_animator_defines.svh"

module rlpa_core
	import rlpa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  rlpa_in_t  cmd,
	input  rlpa_cfg_t cfg,
	output rlpa_res_t res
);

	logic [3:0]  pattern_q;
	logic [31:0] last_q;
	logic        blink_q;
	logic [7:0]  level_q;
	logic        rising_q;

	logic [31:0] diff;
	logic [31:0] interval;
	logic        passed;
	logic        is_blink;
	logic        is_pulse;
	logic        blink_next;
	logic [7:0]  on_level;
	logic [8:0]  level_sum;
	logic [7:0]  level_next;
	logic        rising_next;

	// Measure the wrapping time since the last step against the active interval
	always_comb begin
		is_blink = (pattern_q == PAT_BLINK_BLUE) || (pattern_q == PAT_BLINK_GREEN) ||
			(pattern_q == PAT_BLINK_YELLOW) || (pattern_q == PAT_BLINK_RED);
		is_pulse = (pattern_q == PAT_PULSE_BLUE);
		diff = cmd.now_ms - last_q;
		if (pattern_q == PAT_BLINK_BLUE)
			interval = {16'd0, cfg.slow_blink_ms};
		else if (is_pulse)
			interval = {24'd0, cfg.pulse_tick_ms};
		else
			interval = {16'd0, cfg.fast_blink_ms};
		passed = (diff >= interval);
	end

	// Advance the blink phase and the pulse ramp
	always_comb begin
		blink_next = blink_q ^ passed;
		on_level = blink_next ? LEVEL_MAX : 8'd0;
		level_sum = {1'b0, level_q} + {1'b0, cfg.pulse_step};
		level_next = level_q;
		rising_next = rising_q;
		if (passed) begin
			if (rising_q) begin
				if (level_sum >= {1'b0, LEVEL_MAX}) begin
					level_next = LEVEL_MAX;
					rising_next = 1'b0;
				end else begin
					level_next = level_sum[7:0];
				end
			end else begin
				if (cfg.pulse_step >= level_q) begin
					level_next = 8'd0;
					rising_next = 1'b1;
				end else begin
					level_next = level_q - cfg.pulse_step;
				end
			end
		end
	end

	// Pick the colour of the active pattern; flash and unused codes give nothing
	always_comb begin
		res.valid = accept && (cmd.op == OP_UPDATE);
		res.data = '0;
		case (pattern_q)
			PAT_OFF:          res.data = '0;
			PAT_SOLID_BLUE:   res.data = '{red: 8'd0, green: 8'd0, blue: LEVEL_MAX};
			PAT_SOLID_GREEN:  res.data = '{red: 8'd0, green: LEVEL_MAX, blue: 8'd0};
			PAT_SOLID_YELLOW: res.data = '{red: LEVEL_MAX, green: LEVEL_MAX, blue: 8'd0};
			PAT_SOLID_RED:    res.data = '{red: LEVEL_MAX, green: 8'd0, blue: 8'd0};
			PAT_SOLID_CYAN:   res.data = '{red: 8'd0, green: LEVEL_MAX, blue: LEVEL_MAX};
			PAT_BLINK_BLUE:   res.data = '{red: 8'd0, green: 8'd0, blue: on_level};
			PAT_BLINK_GREEN:  res.data = '{red: 8'd0, green: on_level, blue: 8'd0};
			PAT_BLINK_YELLOW: res.data = '{red: on_level, green: on_level, blue: 8'd0};
			PAT_BLINK_RED:    res.data = '{red: on_level, green: 8'd0, blue: 8'd0};
			PAT_PULSE_BLUE:   res.data = '{red: 8'd0, green: 8'd0, blue: level_next};
			default:          res.valid = 1'b0;
		endcase
	end

	// Update the animation state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PAT_OFF;
			last_q    <= '0;
			blink_q   <= 1'b0;
			level_q   <= '0;
			rising_q  <= 1'b1;
		end else if (accept) begin
			if (cmd.op == OP_SET) begin
				pattern_q <= cmd.pattern;
				last_q    <= cmd.now_ms;
				blink_q   <= 1'b0;
			end else if (is_blink) begin
				blink_q <= blink_next;
				if (passed)
					last_q <= cmd.now_ms;
			end else if (is_pulse) begin
				level_q  <= level_next;
				rising_q <= rising_next;
				if (passed)
					last_q <= cmd.now_ms;
			end
		end
	end

	`RLPA_ASSERT(a_set_clears_phase, accept && (cmd.op == OP_SET) |=> !blink_q,
		"blink phase not cleared by set pattern")
	`RLPA_ASSERT(a_turn_at_top, $fell(rising_q) |-> (level_q == LEVEL_MAX),
		"pulse turned down below the top level")
	`RLPA_ASSERT(a_idle_holds, !accept |=> $stable(level_q) && $stable(pattern_q),
		"animation state moved without a command")
	`RLPA_ASSERT(a_turn_at_bottom, $rose(rising_q) |-> (level_q == 8'd0),
		"pulse turned up above zero")

endmodule

>>> hdl/rlpa_skid.sv
// Output register with a one-entry skid stage for the LED animator results.
// Depends on rlpa_pkg and the assertion macros in rgb_led_pattern_animator_defines.svh.
`include "rgb_led_pattern_animator_defines.svh"

module rlpa_skid
	import rlpa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  rlpa_res_t res,
	output logic      full,
	output logic      out_valid,
	input  logic      out_stall,
	output rlpa_out_t out_data
);

	logic      out_valid_q;
	rlpa_out_t out_data_q;
	logic      skid_valid_q;
	rlpa_out_t skid_data_q;
	logic      out_free;

	assign out_free = !out_valid_q || !out_stall;

	// Refill the output register from the skid stage first, then from the core
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res.valid;
			end
		end else if (res.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Move the payloads alongside
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q)
				out_data_q <= skid_data_q;
			else if (res.valid)
				out_data_q <= res.data;
		end else if (res.valid) begin
			skid_data_q <= res.data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`RLPA_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q,
		"skid stage holds a beat while the output register is empty")
	`RLPA_ASSERT(a_no_write_when_full, skid_valid_q |-> !res.valid,
		"result arrived while the skid stage is full")
	`RLPA_ASSERT(a_stall_fills_skid, out_valid_q && out_stall && res.valid |=> skid_valid_q,
		"stalled result was not parked in the skid stage")

endmodule

>>> tb/rgb_led_pattern_animator_tb.sv
// Self-checking bench for rgb_led_pattern_animator: a directed command table, then random pattern
// runs under several register settings, every beat checked against a predictor or a typed colour.
// Depends on rlpa_pkg and the block's RTL only.
module rgb_led_pattern_animator_tb;
	import rlpa_pkg::*;

	// Pattern codes the package leaves unnamed
	localparam logic [3:0] PAT_FLASH_GREEN  = 4'd11;
	localparam logic [3:0] PAT_SPARE_HI     = 4'd15;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PHASE_ITEMS    = 125;
	localparam int DIRECTED_ROWS  = 25;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	rlpa_in_t    in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	rlpa_out_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_SLOW_BLINK;
	logic [15:0] cfg_data  = '0;

	rgb_led_pattern_animator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor copy of the registers and the animation state
	logic [15:0] cfg_slow    = SLOW_BLINK_RST;
	logic [15:0] cfg_fast    = FAST_BLINK_RST;
	logic [7:0]  cfg_tick    = PULSE_TICK_RST;
	logic [7:0]  cfg_amt     = PULSE_STEP_RST;
	logic [3:0]  anim_pattern = PAT_OFF;
	logic [31:0] step_ms     = '0;
	logic        blink_lit   = 1'b0;
	logic [7:0]  level       = '0;
	logic        rising      = 1'b1;

	rlpa_out_t   colour_q [$];
	int          mismatches  = 0;
	bit          quiet       = 1'b0;
	logic [31:0] sim_ms      = '0;

	// Directed table: rows with fixed set take the typed colour, the rest the predictor's
	typedef struct packed {
		logic        op;
		logic [3:0]  pattern;
		logic [31:0] now_ms;
		logic        fixed;
		rlpa_out_t   colour;
	} plan_row_t;

	plan_row_t plan_rows [0:DIRECTED_ROWS-1] = '{
		'{OP_UPDATE, PAT_OFF,          32'd0,          1'b1, 24'h000000},
		'{OP_SET,    PAT_SOLID_BLUE,   32'd0,          1'b0, 24'h000000},
		'{OP_UPDATE, PAT_OFF,          32'hFFFFFFFF,   1'b1, 24'h0000FF},
		'{OP_SET,    PAT_SOLID_GREEN,  32'd0,          1'b0, 24'h000000},
		'{OP_UPDATE, PAT_SPARE_HI,     32'd1,          1'b1, 24'h00FF00},
		'{OP_SET,    PAT_SOLID_YELLOW, 32'd2,          1'b0, 24'h000000},
		'{OP_UPDATE, PAT_OFF,          32'd3,          1'b1, 24'hFFFF00},
		'{OP_SET,    PAT_SOLID_RED,    32'd4,          1'b0, 24'h000000},
		'{OP_UPDATE, PAT_OFF,          32'd5,          1'b1, 24'hFF0000},
		'{OP_SET,    PAT_SOLID_CYAN,   32'd6,          1'b0, 24'h000000},
		'{OP_UPDATE, PAT_OFF,          32'd7,          1'b1, 24'h00FFFF},
		// blink across the wrap of the millisecond counter
		'{OP_SET,    PAT_BLINK_BLUE,   32'hFFFFFF00,   1'b0, 24'h000000},
		'{OP_UPDATE, PAT_OFF,          32'hFFFFFFFF,   1'b0, 24'h000000},
		'{OP_UPDATE, PAT_OFF,          32'h000002E8,   1'b0, 24'h000000},
		'{OP_SET,    PAT_BLINK_YELLOW, 32'd100,        1'b0, 24'h000000},
		'{OP_UPDATE, PAT_OFF,          32'd350,        1'b0, 24'h000000},
		'{OP_SET,    PAT_PULSE_BLUE,   32'd0,          1'b0, 24'h000000},
		'{OP_UPDATE, PAT_OFF,          32'd10,         1'b0, 24'h000000},
		'{OP_UPDATE, PAT_OFF,          32'd19,         1'b0, 24'h000000},
		// flash and spare codes give nothing on update
		'{OP_SET,    PAT_FLASH_GREEN,  32'd20,         1'b0, 24'h000000},
		'{OP_UPDATE, PAT_OFF,          32'd30,         1'b0, 24'h000000},
		'{OP_SET,    PAT_SPARE_HI,     32'd40,         1'b0, 24'h000000},
		'{OP_UPDATE, PAT_OFF,          32'd50,         1'b0, 24'h000000},
		'{OP_SET,    PAT_BLINK_RED,    32'd60,         1'b0, 24'h000000},
		'{OP_UPDATE, PAT_OFF,          32'd310,        1'b0, 24'h000000}
	};

	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic rlpa_in_t make_cmd(input logic op, input logic [3:0] pat,
			input logic [31:0] now);
		return '{op: op, pattern: pat, now_ms: now};
	endfunction

	function automatic rlpa_out_t rgb(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		return '{red: r, green: g, blue: b};
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] colour check: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	function automatic void apply_reg(input logic [1:0] idx, input logic [15:0] data);
		case (idx)
			CFG_SLOW_BLINK: cfg_slow = data;
			CFG_FAST_BLINK: cfg_fast = data;
			CFG_PULSE_TICK: cfg_tick = data[7:0];
			CFG_PULSE_STEP: cfg_amt  = data[7:0];
			default: ;
		endcase
	endfunction

	// Advance the animation by one command; return 1 when it gives a colour
	function automatic bit advance_animation(input rlpa_in_t cmd, output rlpa_out_t col);
		logic [31:0] span;
		logic [31:0] interval;
		logic [8:0]  sum;
		logic [7:0]  on;
		col = '0;
		if (cmd.op == OP_SET) begin
			anim_pattern = cmd.pattern;
			step_ms      = cmd.now_ms;
			blink_lit    = 1'b0;
			return 1'b0;
		end
		span = cmd.now_ms - step_ms;
		case (anim_pattern)
			PAT_OFF:          col = rgb(8'd0, 8'd0, 8'd0);
			PAT_SOLID_BLUE:   col = rgb(8'd0, 8'd0, LEVEL_MAX);
			PAT_SOLID_GREEN:  col = rgb(8'd0, LEVEL_MAX, 8'd0);
			PAT_SOLID_YELLOW: col = rgb(LEVEL_MAX, LEVEL_MAX, 8'd0);
			PAT_SOLID_RED:    col = rgb(LEVEL_MAX, 8'd0, 8'd0);
			PAT_SOLID_CYAN:   col = rgb(8'd0, LEVEL_MAX, LEVEL_MAX);
			PAT_BLINK_BLUE, PAT_BLINK_GREEN, PAT_BLINK_YELLOW, PAT_BLINK_RED: begin
				interval = (anim_pattern == PAT_BLINK_BLUE) ? {16'd0, cfg_slow} : {16'd0, cfg_fast};
				if (span >= interval) begin
					step_ms   = cmd.now_ms;
					blink_lit = ~blink_lit;
				end
				on = {8{blink_lit}};
				case (anim_pattern)
					PAT_BLINK_BLUE:   col = rgb(8'd0, 8'd0, on);
					PAT_BLINK_GREEN:  col = rgb(8'd0, on, 8'd0);
					PAT_BLINK_YELLOW: col = rgb(on, on, 8'd0);
					default:          col = rgb(on, 8'd0, 8'd0);
				endcase
			end
			PAT_PULSE_BLUE: begin
				if (span >= {24'd0, cfg_tick}) begin
					step_ms = cmd.now_ms;
					if (rising) begin
						sum = {1'b0, level} + {1'b0, cfg_amt};
						if (sum >= {1'b0, LEVEL_MAX}) begin
							level  = LEVEL_MAX;
							rising = 1'b0;
						end else begin
							level = sum[7:0];
						end
					end else if (cfg_amt >= level) begin
						level  = 8'd0;
						rising = 1'b1;
					end else begin
						level = level - cfg_amt;
					end
				end
				col = rgb(8'd0, 8'd0, level);
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// Drive one command beat after a random gap; predict at acceptance
	task automatic send_cmd(input rlpa_in_t cmd, input bit typed, input rlpa_out_t typed_colour);
		int gap;
		rlpa_out_t col;
		gap = draw_wait();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= cmd;
		do @(posedge clk); while (in_stall);
		if (advance_animation(cmd, col))
			colour_q.push_back(typed ? typed_colour : col);
	endtask

	// Hold off the sender until every pending colour has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (colour_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four registers back to back; block must be idle
	task automatic write_regs(input logic [15:0] slow, input logic [15:0] fast,
			input logic [15:0] tick, input logic [15:0] amt);
		logic [15:0] vals [4];
		logic [1:0]  idx [4];
		vals = '{slow, fast, tick, amt};
		idx  = '{CFG_SLOW_BLINK, CFG_FAST_BLINK, CFG_PULSE_TICK, CFG_PULSE_STEP};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			apply_reg(idx[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Random runs: mostly a set followed by updates with advancing time, some noise
	task automatic run_phase(input int count);
		int          sent;
		int          runlen;
		int          pick;
		logic [3:0]  pat;
		logic [31:0] span_max;
		sent = 0;
		while (sent < count) begin
			quiet = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 59) == 0)
				settle();
			if ($urandom_range(0, 7) == 0) begin
				send_cmd(make_cmd(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), $urandom),
					1'b0, '0);
				sent++;
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					pat = 4'($urandom_range(PAT_BLINK_BLUE, PAT_PULSE_BLUE));
				else if (pick < 8)
					pat = 4'($urandom_range(PAT_OFF, PAT_SOLID_CYAN));
				else
					pat = 4'($urandom_range(PAT_FLASH_GREEN, PAT_SPARE_HI));
				case (pat)
					PAT_PULSE_BLUE: span_max = 3 * cfg_tick + 1;
					PAT_BLINK_BLUE: span_max = 2 * cfg_slow + 1;
					default:        span_max = 2 * cfg_fast + 1;
				endcase
				sim_ms = sim_ms + $urandom_range(0, 1000);
				send_cmd(make_cmd(OP_SET, pat, sim_ms), 1'b0, '0);
				sent++;
				runlen = $urandom_range(1, 16);
				for (int k = 0; k < runlen; k++) begin
					// step time back now and then to break the sequence
					if ($urandom_range(0, 9) == 0)
						sim_ms = sim_ms - $urandom_range(1, 50);
					else
						sim_ms = sim_ms + $urandom_range(0, span_max);
					send_cmd(make_cmd(OP_UPDATE, 4'($urandom_range(0, 15)), sim_ms), 1'b0, '0);
					sent++;
				end
			end
		end
		quiet = 1'b0;
	endtask

	// Output side: random stall per beat, compare with the oldest expected colour
	initial begin
		int hold;
		rlpa_out_t want;
		@(posedge arst_n);
		forever begin
			hold = draw_wait();
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (colour_q.size() == 0) begin
				report_mismatch($sformatf("colour %h with nothing pending", out_data));
			end else begin
				want = colour_q.pop_front();
				check_field("red", out_data.red, want.red);
				check_field("green", out_data.green, want.green);
				check_field("blue", out_data.blue, want.blue);
			end
		end
	end

	// Watchdog: end the run after too many cycles without any beat
	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Main sequence: reset, directed table, then register settings with random runs
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < DIRECTED_ROWS; r++)
			send_cmd(make_cmd(plan_rows[r].op, plan_rows[r].pattern, plan_rows[r].now_ms),
				plan_rows[r].fixed, plan_rows[r].colour);
		settle();
		sim_ms = $urandom;

		write_regs(16'd1, 16'd1, 16'd1, 16'd1);
		run_phase(PHASE_ITEMS);
		settle();
		write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_phase(PHASE_ITEMS);
		settle();
		// zero intervals: every update steps
		write_regs(16'd0, 16'd0, 16'd0, 16'd0);
		run_phase(PHASE_ITEMS);
		settle();
		for (int p = 0; p < 3; p++) begin
			write_regs(16'($urandom_range(1, 3000)), 16'($urandom_range(1, 800)),
				16'($urandom_range(1, 40)), 16'($urandom_range(1, 80)));
			run_phase(PHASE_ITEMS);
			settle();
		end

		if (colour_q.size() != 0)
			report_mismatch($sformatf("%0d colours never arrived", colour_q.size()));
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
